// ----- rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared entry, control and neighbor types and the opcode and status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic [15:0] id;
		logic [7:0]  prio;
	} entry_t;

	typedef struct packed {
		logic   ins;
		logic   rem;
		entry_t entry;
	} ctrl_t;

	typedef struct packed {
		logic   valid;
		logic   gt;
		entry_t entry;
	} cell_t;

endpackage

// ----- rtl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the sorted row; shifts toward the tail on insert, toward the head
// on remove.
// ----------------------------------------------------------------------------
module spq_cell
	import spq_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  ctrl_t ctrl,
	input  cell_t left,
	input  cell_t right,
	output cell_t self
);

	logic   valid_q;
	entry_t entry_q;
	logic   gt;

	// An empty slot counts as holding a priority above every real one.
	assign gt = !valid_q || (entry_q.prio > ctrl.entry.prio);

	assign self.valid = valid_q;
	assign self.gt    = gt;
	assign self.entry = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.rem) begin
			valid_q <= right.valid;
		end else if (ctrl.ins && gt) begin
			valid_q <= left.gt ? left.valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rem) begin
			entry_q <= right.entry;
		end else if (ctrl.ins && gt) begin
			entry_q <= left.gt ? left.entry : ctrl.entry;
		end
	end

endmodule

// ----- rtl/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded queue kept in ascending priority order by a row of compare-and-shift
// cells.
// ----------------------------------------------------------------------------
// All cells compare the new priority and shift in the same cycle, so the block accepts
// an insert or a remove on every clock while no held result stalls s_tready, and
// delivers its result from an output register in the cycle after acceptance.
// Equal priorities leave in arrival order. An insert into a full queue or a
// remove from an empty one leaves the queue unchanged and reports a status.
module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // item_id[15:0], item_priority[23:16]
	input  logic [0:0]  s_tuser,  // opcode[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // out_id[15:0], out_priority[23:16], occupancy[28:24]
	output logic [1:0]  m_tuser   // status[1:0]
);

	localparam int CW = $clog2(CAPACITY + 1);

	cell_t           cells [CAPACITY];
	cell_t           lefts [CAPACITY];
	cell_t           rights [CAPACITY];
	ctrl_t           ctrl;
	logic            accept;
	logic            full;
	logic            empty;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   count_next;
	logic [CW+4:0]   count_ext;
	logic [1:0]      status;
	entry_t          out_entry;
	logic            out_valid_q;
	logic [1:0]      status_q;
	entry_t          out_entry_q;
	logic [4:0]      occupancy_q;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign full     = cells[CAPACITY-1].valid;
	assign empty    = !cells[0].valid;

	assign ctrl.ins         = accept && (s_tuser[0] == OP_INSERT) && !full;
	assign ctrl.rem         = accept && (s_tuser[0] == OP_REMOVE) && !empty;
	assign ctrl.entry.id    = s_tdata[15:0];
	assign ctrl.entry.prio  = s_tdata[23:16];

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		if (k == 0) begin : g_head
			assign lefts[k] = '0;
		end else begin : g_left
			assign lefts[k] = cells[k-1];
		end
		if (k == CAPACITY - 1) begin : g_tail
			assign rights[k] = '0;
		end else begin : g_right
			assign rights[k] = cells[k+1];
		end
		spq_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.left   (lefts[k]),
			.right  (rights[k]),
			.self   (cells[k])
		);
	end

	always_comb begin
		count_next = count_q;
		status     = STATUS_OK;
		out_entry  = '0;
		if (s_tuser[0] == OP_INSERT) begin
			if (full) begin
				status = STATUS_FULL;
			end else begin
				count_next = count_q + CW'(1);
			end
		end else begin
			if (empty) begin
				status = STATUS_EMPTY;
			end else begin
				count_next = count_q - CW'(1);
				out_entry  = cells[0].entry;
			end
		end
	end

	assign count_ext = {5'b0, count_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status;
			out_entry_q <= out_entry;
			occupancy_q <= count_ext[4:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {3'b0, occupancy_q, out_entry_q.prio, out_entry_q.id};

endmodule

// ----- tb/sorted_priority_queue_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Sends insert and remove requests with random gaps against a stalling result
// sink and checks every result against a software copy of the sorted queue.
// ----------------------------------------------------------------------------
import spq_pkg::*;

typedef struct packed {
	logic [1:0]  status;
	logic [15:0] id;
	logic [7:0]  prio;
	logic [4:0]  occupancy;
} queue_result_t;

class queue_tracker;
	localparam int DEPTH = 16;

	logic [15:0]   held_id[DEPTH];
	logic [7:0]    held_prio[DEPTH];
	int            held_count;
	queue_result_t due_results[$];
	int            errors;

	function new();
		held_count = 0;
		errors = 0;
	endfunction

	function int pending();
		return due_results.size();
	endfunction

	function void note_request(logic op, logic [15:0] id, logic [7:0] prio);
		queue_result_t r;
		int pos;
		r = '0;
		if (op == OP_INSERT) begin
			if (held_count >= DEPTH) begin
				r.status = STATUS_FULL;
			end else begin
				pos = held_count;
				while (pos > 0 && held_prio[pos - 1] > prio) begin
					held_id[pos] = held_id[pos - 1];
					held_prio[pos] = held_prio[pos - 1];
					pos--;
				end
				held_id[pos] = id;
				held_prio[pos] = prio;
				held_count++;
			end
		end else begin
			if (held_count == 0) begin
				r.status = STATUS_EMPTY;
			end else begin
				r.id = held_id[0];
				r.prio = held_prio[0];
				for (int k = 0; k + 1 < held_count; k++) begin
					held_id[k] = held_id[k + 1];
					held_prio[k] = held_prio[k + 1];
				end
				held_count--;
			end
		end
		r.occupancy = 5'(held_count);
		due_results.push_back(r);
	endfunction

	function void check_result(logic [31:0] data, logic [1:0] user);
		queue_result_t want;
		queue_result_t got;
		got.status = user;
		got.id = data[15:0];
		got.prio = data[23:16];
		got.occupancy = data[28:24];
		if (due_results.size() == 0) begin
			$display("%0t: result with none expected: status %0d id %h prio %h occupancy %0d",
				$time, got.status, got.id, got.prio, got.occupancy);
			errors++;
			return;
		end
		want = due_results.pop_front();
		if (got.status !== want.status) begin
			$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
			errors++;
		end
		if (got.id !== want.id) begin
			$display("%0t: out_id expected %h actual %h", $time, want.id, got.id);
			errors++;
		end
		if (got.prio !== want.prio) begin
			$display("%0t: out_priority expected %h actual %h", $time, want.prio, got.prio);
			errors++;
		end
		if (got.occupancy !== want.occupancy) begin
			$display("%0t: occupancy expected %0d actual %0d", $time, want.occupancy,
				got.occupancy);
			errors++;
		end
	endfunction
endclass

module sorted_priority_queue_test;
	localparam int CLK_HALF = 4;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_BLOCKS = 11;
	localparam int BLOCK_ITEMS = 50;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;

	logic        calm;
	int          cycle_count;
	queue_tracker tracker = new();

	sorted_priority_queue #(
		.CAPACITY(16)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #CLK_HALF clk = ~clk;

	always @(negedge clk) begin
		m_tready = calm || ($urandom_range(0, 99) >= 32);
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			tracker.note_request(s_tuser[0], s_tdata[15:0], s_tdata[23:16]);
		if (arst_n && m_tvalid && m_tready)
			tracker.check_result(m_tdata, m_tuser);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** sorted_priority_queue: FAILED **");
			$finish;
		end
	end

	task automatic send_request(input logic op, input logic [15:0] id, input logic [7:0] prio);
		while (!calm && $urandom_range(0, 99) < 32) begin
			s_tvalid = 1'b0;
			s_tdata = 24'($urandom);
			s_tuser = 1'($urandom_range(0, 1));
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = op;
		s_tdata = {prio, id};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	initial begin
		logic [15:0] fill_id[16];
		logic [7:0]  fill_prio[16];
		int          ins_pct;
		int          prio_mode;
		logic [7:0]  prio;

		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_INSERT;
		m_tready = 1'b0;
		calm = 1'b0;
		cycle_count = 0;

		fill_id = '{16'h0000, 16'hFFFF, 16'h1234, 16'h0001, 16'h0002, 16'h0003, 16'hA5A5,
			16'h5A5A, 16'h8000, 16'h7FFF, 16'h00FF, 16'hFF00, 16'hBEEF, 16'h0F0F, 16'hF0F0,
			16'hCAFE};
		fill_prio = '{8'h00, 8'hFF, 8'h80, 8'h80, 8'h80, 8'h80, 8'hFF, 8'h00, 8'h7F, 8'h01,
			8'hFE, 8'h80, 8'hAA, 8'h55, 8'hFF, 8'h00};

		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_request(OP_REMOVE, 16'hFFFF, 8'hFF);
		for (int i = 0; i < 16; i++)
			send_request(OP_INSERT, fill_id[i], fill_prio[i]);
		send_request(OP_INSERT, 16'hDEAD, 8'h00);
		for (int i = 0; i < 4; i++)
			send_request(OP_REMOVE, 16'($urandom), 8'($urandom));

		for (int b = 0; b < RANDOM_BLOCKS; b++) begin
			calm = (b == 5 || b == 6);
			case ($urandom_range(0, 4))
				0: ins_pct = 10;
				1: ins_pct = 30;
				2: ins_pct = 50;
				3: ins_pct = 70;
				default: ins_pct = 90;
			endcase
			prio_mode = $urandom_range(0, 2);
			for (int i = 0; i < BLOCK_ITEMS; i++) begin
				case (prio_mode)
					0: prio = 8'($urandom_range(0, 3));
					1: prio = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
					default: prio = 8'($urandom);
				endcase
				if ($urandom_range(0, 99) < ins_pct)
					send_request(OP_INSERT, 16'($urandom), prio);
				else
					send_request(OP_REMOVE, 16'($urandom), 8'($urandom));
			end
		end
		calm = 1'b0;
		s_tvalid = 1'b0;

		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (tracker.errors == 0)
			$display("** sorted_priority_queue: PASSED **");
		else
			$display("** sorted_priority_queue: FAILED **");
		$finish;
	end
endmodule

// ----- filelist.f -----
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
tb/sorted_priority_queue_test.sv
